@@ src/bps_pkg.sv @@
`default_nettype none

package bps_pkg;

    localparam int CHUNK_BYTES = 8;
    localparam int LANE_W      = $clog2(CHUNK_BYTES);
    localparam int LEN_W       = 5;
    localparam int POS_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEXT_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH      = 2'd2;

    typedef struct packed {
        logic [63:0] chunk_bytes;
        logic [3:0]  chunk_count;
        logic        last_chunk;
    } chunk_t;

    typedef struct packed {
        logic        found;
        logic [31:0] match_offset;
    } result_t;

    // lane stage -> merge stage
    typedef struct packed {
        logic [CHUNK_BYTES-1:0] hit;
        logic [POS_W-1:0]       base_pos;
        logic [LEN_W-1:0]       len;
        logic                   last;
    } lane_res_t;

endpackage

`default_nettype wire

@@ src/bps_cfg.sv @@
`default_nettype none

module bps_cfg
    import bps_pkg::*;
#(
    parameter int MAX_PATTERN = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [CFG_IDX_W-1:0]        wr_index,
    input  wire logic [CFG_DATA_W-1:0]       wr_value,
    output logic      [MAX_PATTERN*8-1:0]    apat,
    output logic      [MAX_PATTERN-1:0]      amask,
    output logic      [LEN_W-1:0]            eff_len
);

    localparam int SW = $clog2(MAX_PATTERN);

    logic [63:0]          first_reg;
    logic [63:0]          next_reg;
    logic [LEN_W-1:0]     length_reg;
    logic [MAX_PATTERN*8-1:0] pat_vec;
    logic [SW-1:0]        shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            next_reg   <= '0;
            length_reg <= LEN_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_FIRST_BYTES: first_reg  <= wr_value;
                CFG_NEXT_BYTES:  next_reg   <= wr_value;
                CFG_LENGTH:      length_reg <= wr_value[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // zero means one, above the window size saturates
    always_comb
    begin
        eff_len = length_reg;
        if (length_reg == '0)
            eff_len = LEN_W'(1);
        else if (32'(length_reg) > MAX_PATTERN)
            eff_len = LEN_W'(MAX_PATTERN);
    end

    // bytes past 16 have no register
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (k < 8)
                pat_vec[8*k +: 8] = first_reg[8*k +: 8];
            else if (k < 16)
                pat_vec[8*k +: 8] = next_reg[8*(k-8) +: 8];
            else
                pat_vec[8*k +: 8] = 8'h00;
        end
    end

    // right-align the pattern against the window end
    assign shift = SW'(MAX_PATTERN - int'(eff_len));
    assign apat  = pat_vec << {shift, 3'b000};
    assign amask = {MAX_PATTERN{1'b1}} << shift;

endmodule

`default_nettype wire

@@ src/bps_lanes.sv @@
`default_nettype none

module bps_lanes
    import bps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int LANES       = 8
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     chunk_valid,
    output logic                          chunk_stall,
    input  wire chunk_t                   chunk,
    input  wire logic [MAX_PATTERN*8-1:0] apat,
    input  wire logic [MAX_PATTERN-1:0]   amask,
    input  wire logic [LEN_W-1:0]         eff_len,
    input  wire logic                     merge_ready,
    output logic                          s1_valid,
    output lane_res_t                     s1_res
);

    localparam int HD  = MAX_PATTERN - 1;
    localparam int NL  = (LANES < CHUNK_BYTES) ? LANES : CHUNK_BYTES;
    localparam int SQ  = HD + CHUNK_BYTES;
    localparam int SIW = $clog2(SQ);

    logic [7:0]       hist_reg [HD];
    logic [7:0]       hist_next [HD];
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             s1_valid_reg;
    lane_res_t        s1_res_reg;
    lane_res_t        lane_res;
    logic [7:0]       seq [SQ];
    logic [3:0]       cnt;
    logic [POS_W:0]   pos_sum;
    logic             accept;
    logic [SIW-1:0]   idx;

    assign chunk_stall = s1_valid_reg && !merge_ready;
    assign accept      = chunk_valid && !chunk_stall;

    always_comb
    begin
        cnt = chunk.chunk_count;
        if (32'(chunk.chunk_count) > NL)
            cnt = 4'(NL);
    end

    // history followed by the new bytes
    always_comb
    begin
        for (int i = 0; i < HD; i++)
            seq[i] = hist_reg[i];
        for (int i = 0; i < CHUNK_BYTES; i++)
            seq[HD+i] = chunk.chunk_bytes[8*i +: 8];
    end

    // lane l sees the window seq[l .. l+MAX_PATTERN-1]
    always_comb
    begin
        logic mism;
        lane_res.hit = '0;
        for (int l = 0; l < NL; l++)
        begin
            mism = 1'b0;
            for (int j = 0; j < MAX_PATTERN; j++)
                mism = mism | (amask[j] && (seq[l+j] != apat[8*j +: 8]));
            lane_res.hit[l] = !mism && (32'(cnt) > l)
                && ((33'(pos_reg) + 33'(l + 1)) >= 33'(eff_len));
        end
        lane_res.base_pos = pos_reg;
        lane_res.len      = eff_len;
        lane_res.last     = chunk.last_chunk;
    end

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < HD; i++)
        begin
            idx          = SIW'(i) + SIW'(cnt);
            hist_next[i] = seq[idx];
        end
    end

    assign pos_sum = 33'(pos_reg) + 33'(cnt);

    always_comb
    begin
        if (chunk.last_chunk)
            pos_next = '0;
        else if (pos_sum[POS_W])
            pos_next = POS_MAX;
        else
            pos_next = pos_sum[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg      <= pos_next;
                s1_valid_reg <= 1'b1;
            end
            else if (merge_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // stale bytes are masked by the position count
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_reg   <= hist_next;
            s1_res_reg <= lane_res;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_res   = s1_res_reg;

    a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !chunk.last_chunk |=> pos_reg >= $past(pos_reg))
        else $error("byte position went backwards within a haystack");

    a_no_idle_lane_hit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_res_reg.hit >> NL) == '0)
        else $error("hit reported on a lane that does not exist");

endmodule

`default_nettype wire

@@ src/bps_merge.sv @@
`default_nettype none

module bps_merge
    import bps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s1_valid,
    input  wire lane_res_t s1_res,
    output logic           merge_ready,
    output logic           result_valid,
    input  wire logic      result_stall,
    output result_t        result
);

    logic             res_valid_reg;
    result_t          res_reg;
    result_t          res_next;
    logic             reported_reg;
    logic             take;
    logic             any_hit;
    logic             emit;
    logic [LANE_W-1:0] first;
    logic [POS_W:0]   seen_sum;
    logic [POS_W-1:0] seen;

    assign merge_ready = !res_valid_reg || !result_stall;
    assign take        = s1_valid && merge_ready;
    assign any_hit     = |s1_res.hit;
    assign emit        = !reported_reg && (any_hit || s1_res.last);

    // lowest lane wins
    always_comb
    begin
        first = '0;
        for (int l = CHUNK_BYTES - 1; l >= 0; l--)
        begin
            if (s1_res.hit[l])
                first = LANE_W'(l);
        end
    end

    assign seen_sum = 33'(s1_res.base_pos) + 33'(first) + 33'd1;
    assign seen     = seen_sum[POS_W] ? POS_MAX : seen_sum[POS_W-1:0];

    always_comb
    begin
        res_next.found        = any_hit;
        res_next.match_offset = any_hit ? (seen - 32'(s1_res.len)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            reported_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                res_valid_reg <= emit;
                if (reported_reg)
                    reported_reg <= !s1_res.last;
                else
                    reported_reg <= any_hit && !s1_res.last;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
            res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_miss_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.found |-> res_reg.match_offset == '0)
        else $error("not-found result carries a nonzero offset");

    a_reported_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && reported_reg |-> res_reg.found)
        else $error("swallow mode entered without a match result");

    a_swallow_silent: assert property (@(posedge clk) disable iff (!rst_n)
        take && reported_reg |=> !res_valid_reg)
        else $error("result emitted for a swallowed chunk");

endmodule

`default_nettype wire

@@ src/byte_pattern_search.sv @@
// byte_pattern_search: first occurrence of a 1..16 byte pattern in a byte stream.
//
// Configuration: write transactions on cfg_valid/cfg_ready (cfg_ready is always
// high). Index 0 and 1 load pattern bytes 0-7 and 8-15, index 2 the length.
// Write only while no search is in flight.
// Input: one chunk of up to 8 bytes per transaction on chunk_valid/chunk_stall,
// earliest byte in the low bits; last_chunk ends the haystack.
// Output: one transaction per haystack on result_valid/result_stall: found with
// the offset of the first match, or not found after the last chunk. Chunks that
// follow a match, up to the last chunk, produce nothing.
// Pipeline: lane results are registered in the lane stage, results in the merge output register.
// Throughput: one chunk per cycle while chunk_stall is low; every lane compares its
// whole window in the lane stage, and the merge stage picks the earliest hit.
// Stall: a valid result holds in the output register while result_stall is high;
// one more chunk is taken into the lane stage if it is empty, then chunk_stall rises.
// Reset: pattern zero, length one, byte position zero, no search in progress.
`default_nettype none

module byte_pattern_search
    import bps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int LANES       = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_value,
    input  wire logic                  chunk_valid,
    output logic                       chunk_stall,
    input  wire chunk_t                chunk,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result
);

    logic [MAX_PATTERN*8-1:0] apat;
    logic [MAX_PATTERN-1:0]   amask;
    logic [LEN_W-1:0]         eff_len;
    logic                     merge_ready;
    logic                     s1_valid;
    lane_res_t                s1_res;

    assign cfg_ready = 1'b1;

    // pattern registers, aligned against the window end
    bps_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_value (cfg_value),
        .apat     (apat),
        .amask    (amask),
        .eff_len  (eff_len)
    );

    // history, byte position and per-lane window compare
    bps_lanes #(
        .MAX_PATTERN (MAX_PATTERN),
        .LANES       (LANES)
    ) u_lanes (
        .clk         (clk),
        .rst_n       (rst_n),
        .chunk_valid (chunk_valid),
        .chunk_stall (chunk_stall),
        .chunk       (chunk),
        .apat        (apat),
        .amask       (amask),
        .eff_len     (eff_len),
        .merge_ready (merge_ready),
        .s1_valid    (s1_valid),
        .s1_res      (s1_res)
    );

    // first hit, offset, swallow tracking, output register
    bps_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1_res       (s1_res),
        .merge_ready  (merge_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
